[hdl/bed_pkg.sv]
`timescale 1ns / 1ps

package bed_pkg;

  localparam int unsigned MAX_PATTERN = 64;
  // Wide enough to hold the pattern length itself, 0 .. MAX_PATTERN.
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned SYM_W = 8;
  localparam int unsigned VAL_W = 7;
  localparam int unsigned LIM_W = 6;
  localparam int unsigned ROW_W = 7;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(3);
  localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  // Controls shared by every cell of the row.
  typedef struct packed {
    logic             init;
    logic             flush;
    logic [SYM_W-1:0] cmp_sym;
    logic [SYM_W-1:0] wr_sym;
    logic [VAL_W-1:0] sat;
  } cell_ctl_t;

endpackage

[hdl/bed_cell.sv]
`timescale 1ns / 1ps

module bed_cell
  import bed_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic             pat_we_i,
  input  logic [VAL_W-1:0] init_i,
  input  logic             go_i,
  input  logic [VAL_W-1:0] left_new_i,
  input  logic [VAL_W-1:0] left_old_i,
  output logic             go_o,
  output logic [VAL_W-1:0] val_o,
  output logic [VAL_W-1:0] old_o
);

  logic [SYM_W-1:0] pat_q;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] old_q;
  logic             active_q;
  logic [VAL_W-1:0] up1, left1, diag, m1, m2;

  always_comb begin
    up1   = val_q + VAL_W'(1);
    left1 = left_new_i + VAL_W'(1);
    diag  = left_old_i + VAL_W'(pat_q != ctl_i.cmp_sym);
    m1    = (up1 < left1) ? up1 : left1;
    m2    = (m1 < diag) ? m1 : diag;
    val_d = (m2 < ctl_i.sat) ? m2 : ctl_i.sat;
  end

  always_ff @(posedge clk_i) begin
    if (pat_we_i) begin
      pat_q <= ctl_i.wr_sym;
    end
    if (ctl_i.init) begin
      val_q <= init_i;
    end else if (go_i) begin
      // The value this cell held before the update is the diagonal of the
      // next cell, which updates in the cycle after.
      old_q <= val_q;
      val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= go_i & ~ctl_i.flush;
    end
  end

  assign go_o  = active_q;
  assign val_o = val_q;
  assign old_o = old_q;

endmodule

[hdl/bounded_edit_distance.sv]
`timescale 1ns / 1ps
// A pattern item is accepted in the idle state. A text item is accepted, then the row
// update runs down the cell chain through each pattern cell up to L, the stored pattern
// length, and then the finish state follows; with an empty pattern the finish state follows
// acceptance directly. The result of a last text item is loaded into the output register
// in the finish state, which stretches while an earlier result waits on m_axis_tready.
// Reset clears the pattern length, closed flag, row index and output valid; limit is 3.

module bounded_edit_distance
  import bed_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LIM_W-1:0] cfg_wdata_i,   // distance_limit
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // symbol
  input  logic [0:0]       s_axis_tuser,  // action
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // distance, zero bit
  output logic [0:0]       m_axis_tuser   // within_limit
);

  state_e           state_q, state_d;
  logic [LIM_W-1:0] limit_q;
  logic [LEN_W-1:0] plen_q, plen_d;
  logic             closed_q;
  logic [ROW_W-1:0] tri_q, tri_d;
  logic [LEN_W-1:0] step_q;
  logic             start_q;
  logic [SYM_W-1:0] sym_q;
  logic             last_q;
  logic [VAL_W-1:0] dp0_q, diag0_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_dist_q;
  logic             out_within_q;

  logic             accept, is_text, first, sweep_end, fin_ok, out_load;
  logic [VAL_W-1:0] sat, row0_d, dist_sat;
  logic [ROW_W:0]   row;
  logic [LEN_W-1:0] widx;
  logic             wr_ok;
  cell_ctl_t        ctl;

  logic [VAL_W-1:0] val [0:MAX_PATTERN];
  logic [VAL_W-1:0] old [0:MAX_PATTERN-1];
  logic             go  [0:MAX_PATTERN-1];

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign is_text = s_axis_tuser[0];
  assign first   = (tri_q == '0);
  assign sat     = VAL_W'({1'b0, limit_q}) + VAL_W'(1);
  assign row     = {1'b0, tri_q} + (ROW_W + 1)'(1);
  assign row0_d  = (row < (ROW_W + 1)'(sat)) ? VAL_W'(row) : sat;

  // Pattern write position: a new pattern starts over once the last one closed.
  assign widx  = closed_q ? '0 : plen_q;
  assign wr_ok = (widx < LEN_W'(MAX_PATTERN));

  assign sweep_end = (state_q == ST_SWEEP) && (step_q == plen_q);
  assign dist_sat  = (val[plen_q] < sat) ? val[plen_q] : sat;
  assign fin_ok    = !last_q || !out_valid_q || m_axis_tready;
  assign out_load  = (state_q == ST_FINISH) && last_q && fin_ok;

  always_comb begin
    ctl.init    = accept && is_text && first;
    ctl.flush   = sweep_end;
    ctl.cmp_sym = sym_q;
    ctl.wr_sym  = s_axis_tdata;
    ctl.sat     = sat;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_text) begin
          state_d = (plen_q == '0) ? ST_FINISH : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SWEEP:  s_axis_tready = 1'b0;
      ST_FINISH: s_axis_tready = 1'b0;
      default:   s_axis_tready = 1'b0;
    endcase
  end

  always_comb begin
    plen_d = plen_q;
    tri_d  = tri_q;
    if (accept) begin
      if (is_text) begin
        if (s_axis_tlast) begin
          tri_d = '0;
        end else begin
          tri_d = (tri_q == ROW_MAX) ? ROW_MAX : tri_q + ROW_W'(1);
        end
      end else begin
        tri_d  = '0;
        plen_d = wr_ok ? widx + LEN_W'(1) : widx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      plen_q      <= '0;
      closed_q    <= 1'b0;
      tri_q       <= '0;
      step_q      <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      plen_q  <= plen_d;
      tri_q   <= tri_d;
      start_q <= accept && is_text && (plen_q != '0);
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept && !is_text) begin
        closed_q <= s_axis_tlast;
      end
      if (accept) begin
        step_q <= LEN_W'(1);
      end else if (state_q == ST_SWEEP) begin
        step_q <= step_q + LEN_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_text) begin
      sym_q   <= s_axis_tdata;
      last_q  <= s_axis_tlast;
      diag0_q <= first ? '0 : dp0_q;
      dp0_q   <= row0_d;
    end
    if (out_load) begin
      out_dist_q   <= dist_sat;
      out_within_q <= (dist_sat <= VAL_W'(limit_q));
    end
  end

  assign val[0] = dp0_q;
  assign old[0] = diag0_q;
  assign go[0]  = start_q;

  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    logic [VAL_W-1:0] init_val;
    logic             we;

    assign init_val = (VAL_W'(j) < sat) ? VAL_W'(j) : sat;
    assign we       = accept && !is_text && wr_ok && (widx == LEN_W'(j - 1));

    if (j < MAX_PATTERN) begin : g_mid
      bed_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .pat_we_i   (we),
        .init_i     (init_val),
        .go_i       (go[j-1]),
        .left_new_i (val[j-1]),
        .left_old_i (old[j-1]),
        .go_o       (go[j]),
        .val_o      (val[j]),
        .old_o      (old[j])
      );
    end else begin : g_end
      bed_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .pat_we_i   (we),
        .init_i     (init_val),
        .go_i       (go[j-1]),
        .left_new_i (val[j-1]),
        .left_old_i (old[j-1]),
        .go_o       (),
        .val_o      (val[j]),
        .old_o      ()
      );
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_dist_q};
  assign m_axis_tuser  = out_within_q;

endmodule
